// ===== hdl/adaptive_beat_detector_unit_assert.svh =====
// Assertion macros for the beat detector checker.
`ifndef ADAPTIVE_BEAT_DETECTOR_UNIT_ASSERT_SVH
`define ADAPTIVE_BEAT_DETECTOR_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define ABD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Signal holds its value on the edge after the condition.
`define ABD_ASSERT_STABLE(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);
`endif

// ===== hdl/abd_pkg.sv =====
//------------------------------------------------------------------------------
// abd_pkg
// Types and constants shared by the beat detector files.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package abd_pkg;
  localparam int unsigned FeatW = 24;
  localparam int unsigned TimeW = 32;
  localparam int unsigned PerW  = 24;
  localparam int unsigned RatW  = 16;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgFpm    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMargin = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMinUpd = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRebase = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDefPer = 3'd4;

  localparam int unsigned DivW = 64;

  typedef enum logic [3:0] {
    StIdle, StFront, StDivRat, StDivQ, StRest, StDivUpd, StBlend, StDivBl,
    StFin, StOut
  } state_e;

  typedef struct packed {
    logic       beat;
    logic [23:0] period_q8;
    logic [15:0] power_ratio_q8;
    logic [31:0] interval_ms;
  } result_t;

  typedef struct packed {
    logic signed [23:0] power;
    logic signed [23:0] distinctiveness;
    logic signed [23:0] slope;
    logic        [31:0] now_ms;
  } frame_t;
endpackage

// ===== hdl/abd_stream_if.sv =====
//------------------------------------------------------------------------------
// abd_stream_if
// Valid/ready channel carrying one payload per transaction.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
interface abd_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/abd_divider.sv =====
//------------------------------------------------------------------------------
// abd_divider
// Radix-2 restoring divider, unsigned, one quotient bit per cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module abd_divider import abd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] num_i,
  input  logic [DivW-1:0] den_i,
  output logic            done_o,
  output logic [DivW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(DivW + 1);
  logic [DivW-1:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW:0]   trial;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[DivW-1]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      cnt_d = CntW'(DivW);
    end else if (cnt_q != '0) begin
      if (!trial[DivW]) rem_d = trial[DivW-1:0];
      else rem_d = {rem_q[DivW-2:0], quo_q[DivW-1]};
      quo_d = {quo_q[DivW-2:0], !trial[DivW]};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = (cnt_q == CntW'(1));
  assign quo_o  = quo_d;
endmodule

// ===== hdl/adaptive_beat_detector_unit.sv =====
//------------------------------------------------------------------------------
// adaptive_beat_detector_unit
// Beat detector with adaptive feature averages and beat period.
//------------------------------------------------------------------------------
// One frame per transaction; one result per frame. A frame runs through a
// sequencer around a shared bit-serial divider: a frame without a beat does
// the ratio division only, a beat that does not adapt adds rounding, and an
// adapting beat runs ratio, rounding, an optional period refinement and
// three blends. Frontier products come from one 24x16 multiply; a pending
// frontier update holds the input off until front_q is written. A new frame
// is taken while the previous result still waits; only the final output
// step waits for the result register to drain.
`timescale 1ns / 1ps
module adaptive_beat_detector_unit import abd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  abd_stream_if.sink         in_if,
  abd_stream_if.source       out_if,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);
  state_e state_q, state_d;

  logic [15:0] fpm_q, minupd_q, rebase_q, defper_q;
  logic [7:0]  margin_q;
  logic signed [31:0] avg_q [3];
  logic [23:0] per_q;
  logic [15:0] fc_q, front_q;
  logic [5:0]  uc_q;
  logic [4:0]  th_q [3];
  logic [31:0] tb_q;
  logic        front_req_q;

  frame_t  fr_q;
  result_t res_q;
  logic    res_v_q;
  logic    beat_q, adapt_q;
  logic [31:0] iv_q;
  logic signed [40:0] rest_q;
  logic [1:0] bi_q;

  // divider
  logic div_start;
  logic [DivW-1:0] div_num, div_den, div_quo;
  logic div_done;
  abd_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  logic [15:0] defper_eff;
  assign defper_eff = (defper_q == '0) ? 16'd1 : defper_q;

  // frontier product: combinational 24x16 multiply
  logic [39:0] fprod;
  assign fprod = per_q * fpm_q;

  function automatic logic [31:0] absv(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] feat_of(input frame_t f, input logic [1:0] i);
    case (i)
      2'd0: return 32'(f.power);
      2'd1: return 32'(f.distinctiveness);
      default: return 32'(f.slope);
    endcase
  endfunction

  // blend numerator
  logic signed [41:0] bl_sum;
  logic [41:0] bl_mag;
  assign bl_sum = 42'(avg_q[bi_q]) * 4 + (42'(feat_of(fr_q, bi_q)) <<< 8);
  assign bl_mag = bl_sum[41] ? 42'(-bl_sum) : 42'(bl_sum);

  // update numerator (|rest| / uc)
  logic [40:0] rest_mag;
  assign rest_mag = rest_q[40] ? 41'(-rest_q) : 41'(rest_q);

  logic [23:0] per_eff;
  assign per_eff = (per_q == '0) ? 24'd1 : per_q;

  logic [15:0] fc_inc;
  logic signed [18:0] c_s, f_s, m_s;
  logic [37:0] pmag [3];
  logic [37:0] tmag [3];
  logic pass [3];
  logic signed [31:0] avg_seed [3];
  logic [4:0] th_new [3];
  logic in_ready;

  assign in_ready = (state_q == StIdle) && !front_req_q;
  assign in_if.ready = in_ready;
  assign out_if.valid = res_v_q;
  assign out_if.data  = res_q;

  always_comb begin
    fc_inc = (fc_q == 16'hFFFF) ? fc_q : fc_q + 1'b1;
    c_s = 19'(fc_inc);
    f_s = 19'(front_q);
    m_s = 19'(margin_q);
    for (int i = 0; i < 3; i++) th_new[i] = th_q[i];
    if (c_s == f_s - m_s) for (int i = 0; i < 3; i++) th_new[i] = 5'd6;
    else if (c_s == 19'sd1) for (int i = 0; i < 3; i++) th_new[i] = 5'd18;
    else if (c_s == f_s + m_s) for (int i = 0; i < 3; i++) th_new[i] = 5'd12;
    else if (c_s == 2 * f_s - m_s) for (int i = 0; i < 3; i++) th_new[i] = 5'd6;
    else if (c_s == 2 * f_s + m_s) begin
      th_new[0] = 5'd9; th_new[1] = 5'd9; th_new[2] = 5'd6;
    end
    for (int i = 0; i < 3; i++) begin
      avg_seed[i] = (avg_q[i] == 0) ? (feat_of(in_if.data, 2'(i)) <<< 8) : avg_q[i];
      pmag[i] = 38'(absv(feat_of(in_if.data, 2'(i)))) * 38'd2560;
      tmag[i] = 38'(th_new[i]) * 38'(absv(avg_seed[i]));
      pass[i] = (avg_seed[i] != 0) && (pmag[i] > tmag[i]);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    case (state_q)
      StIdle: if (in_if.valid && in_ready) state_d = StDivRat;
      StDivRat: begin
        div_num = DivW'(absv(feat_of(fr_q, 2'd0))) << 16;
        div_den = DivW'(absv(avg_q[0]));
        div_start = 1'b1;
        state_d = StFront;
      end
      StFront: if (div_done) state_d = beat_q ? StDivQ : StOut;
      StDivQ: begin
        div_num = (DivW'(iv_q) << 9) + DivW'(per_eff);
        div_den = DivW'(per_eff) << 1;
        div_start = 1'b1;
        state_d = StRest;
      end
      StRest: if (div_done) state_d = (adapt_q && uc_q >= 6'd12 && uc_q != 6'd40)
                                      ? StDivUpd : (adapt_q ? StBlend : StFin);
      StDivUpd: begin
        div_num = DivW'(rest_mag);
        div_den = DivW'(uc_q);
        div_start = 1'b1;
        state_d = StDivBl;
      end
      StBlend: begin
        div_num = DivW'(bl_mag);
        div_den = DivW'(5);
        div_start = 1'b1;
        state_d = StDivBl;
      end
      StDivBl: if (div_done) state_d = (bi_q == 2'd3) ? StBlend :
                                       ((bi_q == 2'd2) ? StFin : StBlend);
      StFin: state_d = StOut;
      StOut: if (!res_v_q || out_if.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  logic [15:0] ratio_q;
  logic signed [41:0] np;

  // refined period: old period plus the signed remainder share
  assign np = 42'(per_eff) + (rest_q[40] ? -42'(div_quo[40:0]) : 42'(div_quo[40:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpm_q <= 16'd192; margin_q <= 8'd20; minupd_q <= 16'd400;
      rebase_q <= 16'd300; defper_q <= 16'd500;
      for (int i = 0; i < 3; i++) begin avg_q[i] <= '0; th_q[i] <= 5'd8; end
      per_q <= 24'd500 << 8; fc_q <= '0; uc_q <= '0; tb_q <= '0;
      front_q <= '0; front_req_q <= 1'b1;
      res_v_q <= 1'b0; beat_q <= 1'b0; adapt_q <= 1'b0; bi_q <= '0;
      ratio_q <= '0; iv_q <= '0; rest_q <= '0;
    end else begin
      if (out_if.valid && out_if.ready) res_v_q <= 1'b0;
      if (front_req_q) begin
        front_q <= (fprod[39:32] != '0) ? 16'hFFFF : fprod[31:16];
        front_req_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgFpm: begin fpm_q <= cfg_data_i; front_req_q <= 1'b1; end
          CfgMargin: margin_q <= cfg_data_i[7:0];
          CfgMinUpd: minupd_q <= cfg_data_i;
          CfgRebase: rebase_q <= cfg_data_i;
          CfgDefPer: begin
            defper_q <= cfg_data_i;
            if (uc_q < 6'd12) begin
              per_q <= {(cfg_data_i == '0) ? 16'd1 : cfg_data_i, 8'd0};
              front_req_q <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      case (state_q)
        StIdle: if (in_if.valid && in_ready) begin
          fr_q <= in_if.data;
          fc_q <= fc_inc;
          for (int i = 0; i < 3; i++) begin
            th_q[i] <= th_new[i];
            avg_q[i] <= avg_seed[i];
          end
          beat_q <= pass[0] && pass[1] && pass[2];
          iv_q <= in_if.data.now_ms - tb_q;
          adapt_q <= (in_if.data.now_ms - tb_q) > 32'(minupd_q);
          bi_q <= '0;
        end
        StFront: if (div_done) begin
          ratio_q <= (avg_q[0] == 0) ? 16'd0 :
                     ((div_quo[DivW-1:16] != '0) ? 16'hFFFF : div_quo[15:0]);
        end
        StRest: if (div_done) begin
          rest_q <= 41'(iv_q) * 256 - 41'(per_eff) * div_quo[40:0];
          if (fc_q > rebase_q) tb_q <= fr_q.now_ms;
          if (adapt_q) begin
            if (uc_q == 6'd40) uc_q <= 6'd21;
            else if (uc_q < 6'd12) begin
              per_q <= {defper_eff, 8'd0};
              uc_q <= uc_q + 1'b1;
            end
          end
          bi_q <= (adapt_q && uc_q >= 6'd12 && uc_q != 6'd40) ? 2'd3 : 2'd0;
        end
        StDivBl: if (div_done) begin
          if (bi_q == 2'd3) begin
            per_q <= (np < 1) ? 24'd1 : ((np > 42'sh0FFFFFF) ? 24'hFFFFFF : np[23:0]);
            uc_q <= uc_q + 1'b1;
            bi_q <= 2'd0;
          end else begin
            avg_q[bi_q] <= bl_sum[41] ? -32'(div_quo[31:0]) : 32'(div_quo[31:0]);
            bi_q <= bi_q + 1'b1;
          end
        end
        StFin: begin
          fc_q <= '0;
          front_req_q <= 1'b1;
        end
        StOut: if (!res_v_q || out_if.ready) begin
          res_v_q <= 1'b1;
          res_q.beat <= beat_q;
          res_q.period_q8 <= per_q;
          res_q.power_ratio_q8 <= ratio_q;
          res_q.interval_ms <= beat_q ? iv_q : 32'd0;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== hdl/adaptive_beat_detector_unit_checker.sv =====
//------------------------------------------------------------------------------
// adaptive_beat_detector_unit_checker
// Port-level checks of the beat detector, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adaptive_beat_detector_unit_assert.svh"
module adaptive_beat_detector_unit_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_beat_i,
  input logic [31:0] out_interval_i
);
  `ABD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")
  `ABD_ASSERT(a_no_beat_iv, clk_i, rst_ni, out_valid_i && !out_beat_i |-> out_interval_i == 0, "interval without beat")
  `ABD_ASSERT(a_one_busy, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i, "second frame taken while busy")
  `ABD_ASSERT_STABLE(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, {out_beat_i, out_interval_i}, "result changed while waiting")
endmodule

bind adaptive_beat_detector_unit adaptive_beat_detector_unit_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_beat_i(out_if.data.beat),
  .out_interval_i(out_if.data.interval_ms)
);
